// ===== rtl/srect_pkg.sv =====
// shared types, constants and helpers for the shelf rectangle allocator
package srect_pkg;

   localparam int MAX_SHELVES = 64;
   localparam int IDX_W       = $clog2(MAX_SHELVES);
   localparam int CNT_W       = $clog2(MAX_SHELVES + 1);
   localparam int DIM_W       = 13;
   localparam int FREE_W      = DIM_W + 1;
   localparam int MUL_W       = DIM_W + 4;
   localparam int GUTTER      = 2;
   localparam int FIT_NUM     = 10;
   localparam int FIT_DEN     = 7;
   localparam int ATLAS_RESET = 2048;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_HEIGHT = CSR_IDX_W'(1);

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_UPDATE,
      FSM_SPLIT,
      FSM_FINISH
   } fsm_type;

   typedef struct packed {
      op_type             operation;
      logic [DIM_W-1:0]   rect_left;
      logic [DIM_W-1:0]   rect_top;
      logic [DIM_W-1:0]   rect_width;
      logic [DIM_W-1:0]   rect_height;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [DIM_W-1:0]   placed_left;
      logic [DIM_W-1:0]   placed_top;
      logic [DIM_W-1:0]   placed_width;
      logic [DIM_W-1:0]   placed_height;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0]          top;
      logic [DIM_W-1:0]          height;
      logic [DIM_W-1:0]          left;
      logic [DIM_W-1:0]          width;
      logic signed [FREE_W-1:0]  free;
   } shelf_type;

   typedef struct packed {
      logic alloc_fit;
      logic free_fit;
   } fit_type;

   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W:0] v);
      return v[DIM_W] ? '1 : v[DIM_W-1:0];
   endfunction

endpackage

// ===== rtl/srect_ram.sv =====
// generic single write, single read memory with registered read data
module srect_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/srect_fit.sv =====
// compare unit: does one shelf entry take an allocate, or hold a freed rectangle
module srect_fit (
   input  srect_pkg::shelf_type entry,
   input  srect_pkg::req_type   req,
   output srect_pkg::fit_type   fit
);

   logic signed [srect_pkg::FREE_W-1:0] w_s;
   logic signed [srect_pkg::FREE_W-1:0] h_s;
   logic signed [srect_pkg::FREE_W-1:0] sh_m1;
   logic [srect_pkg::MUL_W-1:0]         h_scaled;
   logic [srect_pkg::MUL_W-1:0]         sh_scaled;
   logic [srect_pkg::DIM_W:0]           rect_right;
   logic [srect_pkg::DIM_W:0]           shelf_right;

   always_comb begin
      w_s   = $signed({1'b0, req.rect_width});
      h_s   = $signed({1'b0, req.rect_height});
      sh_m1 = $signed({1'b0, entry.height}) - srect_pkg::FREE_W'(1);
      // height ratio test: h*10 >= sh*7
      h_scaled  = srect_pkg::MUL_W'(req.rect_height) * srect_pkg::MUL_W'(srect_pkg::FIT_NUM);
      sh_scaled = srect_pkg::MUL_W'(entry.height) * srect_pkg::MUL_W'(srect_pkg::FIT_DEN);
      rect_right  = {1'b0, req.rect_left} + {1'b0, req.rect_width};
      shelf_right = {1'b0, entry.left} + {1'b0, entry.width};

      fit.alloc_fit = (entry.free > w_s) && (h_s < sh_m1) && (h_scaled >= sh_scaled);
      fit.free_fit  = (entry.top == req.rect_top) && (req.rect_left >= entry.left) &&
                      (rect_right <= shelf_right);
   end

endmodule

// ===== rtl/shelf_rect_allocator.sv =====
// shelf rectangle allocator top level: sequencer, shelf table and result register
//
// usage: a request word on req_data (allocate or free) is taken when req_valid
// is high and req_stall low. every request gives exactly one response word on
// rsp_data, handed over when rsp_valid is high and rsp_stall low.
// atlas_width / atlas_height are written through csr_we, csr_index, csr_wdata
// while the block is idle; both reset to 2048.
// a request walks the shelf table in order, one entry per cycle through the
// table memory read port and the shared compare unit, stopping at the first hit.
// a rejected allocate goes from accept straight to the finish state; any other
// request walks up to MAX_SHELVES entries, then a hit passes the update state and a
// free that splits a shelf the split state, and every request ends in the finish state.
// the next request can be taken in the cycle after the response word is loaded.
// req_stall is high from accept until the response is in the output register;
// a waiting response does not block the next request, which is accepted and
// walked while rsp_stall holds the previous word.
// reset empties the shelf table (count zero, row start zero) and clears
// rsp_valid; no clearing pass is needed.
module shelf_rect_allocator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  srect_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output srect_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_we,
   input  logic [srect_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [srect_pkg::DIM_W-1:0]           csr_wdata
);

   localparam logic [srect_pkg::CNT_W-1:0] CNT_MAX = srect_pkg::CNT_W'(srect_pkg::MAX_SHELVES);

   srect_pkg::fsm_type                 state_ff, state_in;
   srect_pkg::req_type                 req_ff, req_in;
   logic [srect_pkg::CNT_W-1:0]        idx_ff, idx_in;
   logic                               chk_vld_ff, chk_vld_in;
   logic [srect_pkg::IDX_W-1:0]        chk_idx_ff, chk_idx_in;
   srect_pkg::shelf_type               hit_ff, hit_in;
   logic [srect_pkg::IDX_W-1:0]        hit_idx_ff, hit_idx_in;
   logic [srect_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [srect_pkg::DIM_W-1:0]        next_top_ff, next_top_in;
   logic [srect_pkg::DIM_W-1:0]        atlas_w_ff, atlas_w_in;
   logic [srect_pkg::DIM_W-1:0]        atlas_h_ff, atlas_h_in;
   srect_pkg::rsp_type                 res_ff, res_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   srect_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic                               wr_en;
   logic [srect_pkg::IDX_W-1:0]        wr_addr;
   srect_pkg::shelf_type               wr_data;
   logic [srect_pkg::IDX_W-1:0]        rd_addr;
   logic [$bits(srect_pkg::shelf_type)-1:0] rd_raw;
   srect_pkg::shelf_type               rd_entry;
   srect_pkg::fit_type                 fit;

   logic                               load_rsp;
   logic                               alloc_reject;
   logic                               hit_now;
   logic                               table_full;
   srect_pkg::shelf_type               new_shelf;
   srect_pkg::shelf_type               rem_shelf;
   srect_pkg::shelf_type               upd_shelf;
   logic [srect_pkg::DIM_W:0]          rect_right;
   logic [srect_pkg::DIM_W:0]          shelf_right;
   logic [srect_pkg::FREE_W-1:0]       place_x;

   srect_ram #(
      .WIDTH ($bits(srect_pkg::shelf_type)),
      .DEPTH (srect_pkg::MAX_SHELVES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = srect_pkg::shelf_type'(rd_raw);

   srect_fit u_fit (
      .entry (rd_entry),
      .req   (req_ff),
      .fit   (fit)
   );

   // config registers
   always_comb begin
      atlas_w_in = atlas_w_ff;
      atlas_h_in = atlas_h_ff;
      if (csr_we) begin
         case (csr_index)
            srect_pkg::CSR_ATLAS_WIDTH:  atlas_w_in = csr_wdata;
            srect_pkg::CSR_ATLAS_HEIGHT: atlas_h_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // entry images built from the request and the held hit
   always_comb begin
      alloc_reject = (req_data.rect_width > atlas_w_ff) ||
                     (({1'b0, next_top_ff} + {1'b0, req_data.rect_height}) > {1'b0, atlas_h_ff});
      hit_now    = (req_ff.operation == srect_pkg::OP_ALLOC) ? fit.alloc_fit : fit.free_fit;
      table_full = (count_ff == CNT_MAX);

      // new shelf already charged with this rectangle and its gutter
      new_shelf.top    = next_top_ff;
      new_shelf.height = srect_pkg::sat_dim({1'b0, req_ff.rect_height} +
                                            (srect_pkg::DIM_W + 1)'(srect_pkg::GUTTER));
      new_shelf.left   = '0;
      new_shelf.width  = atlas_w_ff;
      new_shelf.free   = $signed({1'b0, atlas_w_ff}) - $signed({1'b0, req_ff.rect_width}) -
                         srect_pkg::FREE_W'(srect_pkg::GUTTER);

      rect_right  = {1'b0, req_ff.rect_left} + {1'b0, req_ff.rect_width};
      shelf_right = {1'b0, hit_ff.left} + {1'b0, hit_ff.width};

      // remainder shelf right of the freed rectangle
      rem_shelf.top    = hit_ff.top;
      rem_shelf.height = hit_ff.height;
      rem_shelf.left   = rect_right[srect_pkg::DIM_W-1:0];
      rem_shelf.width  = srect_pkg::DIM_W'(shelf_right - rect_right);
      rem_shelf.free   = hit_ff.free;

      // narrowed original shelf
      upd_shelf       = hit_ff;
      upd_shelf.width = hit_ff.width - rem_shelf.width;
      upd_shelf.free  = $signed({1'b0, req_ff.rect_width});

      // placement x wraps modulo the field width
      place_x = shelf_right - hit_ff.free;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      idx_in      = idx_ff;
      chk_vld_in  = 1'b0;
      chk_idx_in  = chk_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      count_in    = count_ff;
      next_top_in = next_top_ff;
      res_in      = res_ff;
      wr_en       = 1'b0;
      wr_addr     = count_ff[srect_pkg::IDX_W-1:0];
      wr_data     = new_shelf;
      rd_addr     = idx_ff[srect_pkg::IDX_W-1:0];
      load_rsp    = 1'b0;

      case (state_ff)
         srect_pkg::FSM_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               idx_in = '0;
               res_in = '0;
               if (req_data.operation == srect_pkg::OP_ALLOC && alloc_reject) begin
                  res_in.status = srect_pkg::ST_MISS;
                  state_in      = srect_pkg::FSM_FINISH;
               end else begin
                  state_in = srect_pkg::FSM_SCAN;
               end
            end
         end
         srect_pkg::FSM_SCAN: begin
            if (chk_vld_ff && hit_now) begin
               hit_in     = rd_entry;
               hit_idx_in = chk_idx_ff;
               state_in   = srect_pkg::FSM_UPDATE;
            end else if (!chk_vld_ff && idx_ff == count_ff) begin
               // walked every shelf without a hit
               state_in = srect_pkg::FSM_FINISH;
               if (req_ff.operation == srect_pkg::OP_FREE) begin
                  res_in.status = srect_pkg::ST_MISS;
               end else if (table_full) begin
                  res_in.status = srect_pkg::ST_FULL;
               end else begin
                  wr_en               = 1'b1;
                  next_top_in         = srect_pkg::sat_dim({1'b0, next_top_ff} +
                                                           {1'b0, new_shelf.height});
                  count_in            = count_ff + 1'b1;
                  res_in.status       = srect_pkg::ST_DONE;
                  res_in.placed_left  = '0;
                  res_in.placed_top   = next_top_ff;
                  res_in.placed_width = req_ff.rect_width;
                  res_in.placed_height = req_ff.rect_height;
               end
            end else if (idx_ff != count_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = idx_ff[srect_pkg::IDX_W-1:0];
               idx_in     = idx_ff + 1'b1;
            end
         end
         srect_pkg::FSM_UPDATE: begin
            if (req_ff.operation == srect_pkg::OP_ALLOC) begin
               wr_en        = 1'b1;
               wr_addr      = hit_idx_ff;
               wr_data      = hit_ff;
               wr_data.free = hit_ff.free - $signed({1'b0, req_ff.rect_width}) -
                              srect_pkg::FREE_W'(srect_pkg::GUTTER);
               res_in.status        = srect_pkg::ST_DONE;
               res_in.placed_left   = place_x[srect_pkg::DIM_W-1:0];
               res_in.placed_top    = hit_ff.top;
               res_in.placed_width  = req_ff.rect_width;
               res_in.placed_height = req_ff.rect_height;
               state_in = srect_pkg::FSM_FINISH;
            end else if (table_full) begin
               res_in.status = srect_pkg::ST_FULL;
               state_in      = srect_pkg::FSM_FINISH;
            end else begin
               wr_en    = 1'b1;
               wr_data  = rem_shelf;
               state_in = srect_pkg::FSM_SPLIT;
            end
         end
         srect_pkg::FSM_SPLIT: begin
            wr_en         = 1'b1;
            wr_addr       = hit_idx_ff;
            wr_data       = upd_shelf;
            count_in      = count_ff + 1'b1;
            res_in.status = srect_pkg::ST_DONE;
            state_in      = srect_pkg::FSM_FINISH;
         end
         srect_pkg::FSM_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = srect_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = srect_pkg::FSM_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = load_rsp | (rsp_valid_ff & rsp_stall);
      rsp_data_in  = load_rsp ? res_ff : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srect_pkg::FSM_IDLE;
         chk_vld_ff   <= 1'b0;
         count_ff     <= '0;
         next_top_ff  <= '0;
         atlas_w_ff   <= srect_pkg::DIM_W'(srect_pkg::ATLAS_RESET);
         atlas_h_ff   <= srect_pkg::DIM_W'(srect_pkg::ATLAS_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         count_ff     <= count_in;
         next_top_ff  <= next_top_in;
         atlas_w_ff   <= atlas_w_in;
         atlas_h_ff   <= atlas_h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      chk_idx_ff  <= chk_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != srect_pkg::FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("shelf count beyond table depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != srect_pkg::FSM_IDLE)
      else $error("accepted word left sequencer idle");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == srect_pkg::FSM_SCAN || state_ff == srect_pkg::FSM_UPDATE ||
                 state_ff == srect_pkg::FSM_SPLIT))
      else $error("table write outside update states");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != srect_pkg::ST_DONE |->
         rsp_data.placed_left == '0 && rsp_data.placed_top == '0 &&
         rsp_data.placed_width == '0 && rsp_data.placed_height == '0)
      else $error("failed response carries placement");

endmodule

// ===== test/tb_shelf_rect_allocator.sv =====
// self-checking testbench for the shelf rectangle allocator
`timescale 1ns / 100ps

module tb_shelf_rect_allocator;

   localparam int DIM_MASK    = (1 << srect_pkg::DIM_W) - 1;
   localparam int CYCLE_LIMIT = 400000;

   // mirror of the shelf table: predicts each response word and holds the ones still owed
   class shelf_mirror;
      int      atlas_w;
      int      atlas_h;
      int      top_of[srect_pkg::MAX_SHELVES];
      int      height_of[srect_pkg::MAX_SHELVES];
      int      left_of[srect_pkg::MAX_SHELVES];
      int      width_of[srect_pkg::MAX_SHELVES];
      int      free_of[srect_pkg::MAX_SHELVES];
      int      count;
      int      next_row_top;
      bit      grew;
      srect_pkg::rsp_type awaited[$];
      int      mismatches;
      int      words_seen;
      int      allocs;
      int      frees;
      int      by_status[3];

      function new();
         atlas_w = srect_pkg::ATLAS_RESET;
         atlas_h = srect_pkg::ATLAS_RESET;
         count = 0;
         next_row_top = 0;
         mismatches = 0;
         words_seen = 0;
         allocs = 0;
         frees = 0;
      endfunction

      function void write_reg(logic [srect_pkg::CSR_IDX_W-1:0] idx, int value);
         case (idx)
            srect_pkg::CSR_ATLAS_WIDTH: begin
               atlas_w = value & DIM_MASK;
            end
            srect_pkg::CSR_ATLAS_HEIGHT: begin
               atlas_h = value & DIM_MASK;
            end
            default: begin
            end
         endcase
      endfunction

      function int clip(int v);
         return (v > DIM_MASK) ? DIM_MASK : v;
      endfunction

      // with commit low nothing changes; grew tells whether a table entry would be added
      function srect_pkg::rsp_type place_rect(srect_pkg::req_type it, bit commit);
         srect_pkg::rsp_type r;
         int      w, h, l, t, rgt, sr, hit, n, x;
         int      st_t, st_h, st_l, st_w, st_f;
         w = it.rect_width;
         h = it.rect_height;
         l = it.rect_left;
         t = it.rect_top;
         r = '0;
         r.status = srect_pkg::ST_DONE;
         hit = -1;
         grew = 1'b0;
         if (it.operation == srect_pkg::OP_ALLOC) begin
            if (w > atlas_w || next_row_top + h > atlas_h) begin
               r.status = srect_pkg::ST_MISS;
            end else begin
               for (int i = 0; i < count; i++)
                  if (hit < 0 && free_of[i] > w && h < height_of[i] - 1 &&
                      h * 10 >= height_of[i] * 7)
                     hit = i;
               if (hit < 0 && count >= srect_pkg::MAX_SHELVES) begin
                  r.status = srect_pkg::ST_FULL;
               end else begin
                  if (hit < 0) begin
                     grew = 1'b1;
                     hit = count;
                     st_t = next_row_top;
                     st_h = clip(h + srect_pkg::GUTTER);
                     st_l = 0;
                     st_w = atlas_w;
                     st_f = atlas_w;
                  end else begin
                     st_t = top_of[hit];
                     st_h = height_of[hit];
                     st_l = left_of[hit];
                     st_w = width_of[hit];
                     st_f = free_of[hit];
                  end
                  x = st_l + st_w - st_f;
                  r.placed_left   = srect_pkg::DIM_W'(x);
                  r.placed_top    = srect_pkg::DIM_W'(st_t);
                  r.placed_width  = srect_pkg::DIM_W'(w);
                  r.placed_height = srect_pkg::DIM_W'(h);
                  if (commit) begin
                     top_of[hit]    = st_t;
                     height_of[hit] = st_h;
                     left_of[hit]   = st_l;
                     width_of[hit]  = st_w;
                     free_of[hit]   = st_f - w - srect_pkg::GUTTER;
                     if (grew) begin
                        count++;
                        next_row_top = clip(next_row_top + st_h);
                     end
                  end
               end
            end
         end else begin
            rgt = l + w;
            for (int i = 0; i < count; i++)
               if (hit < 0 && top_of[i] == t && l >= left_of[i] &&
                   rgt <= left_of[i] + width_of[i])
                  hit = i;
            if (hit < 0) begin
               r.status = srect_pkg::ST_MISS;
            end else if (count >= srect_pkg::MAX_SHELVES) begin
               r.status = srect_pkg::ST_FULL;
            end else begin
               grew = 1'b1;
               if (commit) begin
                  // remainder goes to the end of the table, original ends at the right edge
                  n = count;
                  sr = left_of[hit] + width_of[hit];
                  left_of[n]   = rgt & DIM_MASK;
                  width_of[n]  = (sr - rgt) & DIM_MASK;
                  top_of[n]    = top_of[hit];
                  height_of[n] = height_of[hit];
                  free_of[n]   = free_of[hit];
                  free_of[hit] = w;
                  width_of[hit] = (width_of[hit] - width_of[n]) & DIM_MASK;
                  count++;
               end
            end
         end
         return r;
      endfunction

      function srect_pkg::rsp_type take_request(srect_pkg::req_type it);
         srect_pkg::rsp_type r;
         r = place_rect(it, 1'b1);
         awaited.insert(awaited.size(), r);
         if (it.operation == srect_pkg::OP_ALLOC)
            allocs++;
         else
            frees++;
         by_status[r.status]++;
         return r;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      task flag_mismatch(string field, int got, int want);
         mismatches++;
         $display("response word %0d: %s is %0d, expected %0d", words_seen, field, got, want);
      endtask

      task match_result(srect_pkg::rsp_type got);
         srect_pkg::rsp_type want;
         words_seen++;
         if (awaited.size() == 0) begin
            flag_mismatch("word with nothing owed, status", int'(got.status), -1);
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status)
            flag_mismatch("status", int'(got.status), int'(want.status));
         if (got.placed_left !== want.placed_left)
            flag_mismatch("placed_left", got.placed_left, want.placed_left);
         if (got.placed_top !== want.placed_top)
            flag_mismatch("placed_top", got.placed_top, want.placed_top);
         if (got.placed_width !== want.placed_width)
            flag_mismatch("placed_width", got.placed_width, want.placed_width);
         if (got.placed_height !== want.placed_height)
            flag_mismatch("placed_height", got.placed_height, want.placed_height);
      endtask
   endclass

   logic                                clock     = 1'b0;
   logic                                reset     = 1'b1;
   logic                                req_valid = 1'b0;
   srect_pkg::req_type                  req_data  = '0;
   logic                                req_stall;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   srect_pkg::rsp_type                  rsp_data;
   logic                                csr_we    = 1'b0;
   logic [srect_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [srect_pkg::DIM_W-1:0]         csr_wdata = '0;

   int                  gap_pct    = 25;
   int                  stall_pct  = 25;
   int                  stall_left = 0;
   int                  cycles     = 0;
   srect_pkg::rsp_type  placed_q[$];
   shelf_mirror         sb;

   shelf_rect_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("shelf_rect_allocator test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.match_result(rsp_data);
   end

   // receiver back-pressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0)
         stall_left--;
      else if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct)
         stall_left = $urandom_range(1, 11);
      rsp_stall <= (stall_left > 0);
   end

   function automatic srect_pkg::req_type mk(srect_pkg::op_type o, int l, int t, int w, int h);
      srect_pkg::req_type it;
      it.operation   = o;
      it.rect_left   = srect_pkg::DIM_W'(l);
      it.rect_top    = srect_pkg::DIM_W'(t);
      it.rect_width  = srect_pkg::DIM_W'(w);
      it.rect_height = srect_pkg::DIM_W'(h);
      return it;
   endfunction

   // mostly allocates, many near the heights of placed rectangles, and some frees, most of placed rectangles
   function automatic srect_pkg::req_type rand_item();
      srect_pkg::req_type it;
      srect_pkg::rsp_type p;
      int      roll;
      int      base;
      int      wmax;
      it.operation   = srect_pkg::OP_ALLOC;
      it.rect_left   = srect_pkg::DIM_W'($urandom);
      it.rect_top    = srect_pkg::DIM_W'($urandom);
      it.rect_width  = '0;
      it.rect_height = '0;
      roll = $urandom_range(0, 99);
      p = '0;
      if (placed_q.size() > 0)
         p = placed_q[$urandom_range(0, placed_q.size() - 1)];
      if (roll < 22) begin
         it.operation = srect_pkg::OP_FREE;
         if (roll < 16 && placed_q.size() > 0) begin
            it.rect_left = p.placed_left;
            it.rect_top  = p.placed_top;
            it.rect_width = (roll < 10) ? p.placed_width
                                        : srect_pkg::DIM_W'($urandom_range(0, p.placed_width));
         end else begin
            if (roll < 19)
               it.rect_top = p.placed_top;
            if (roll < 20)
               it.rect_left = srect_pkg::DIM_W'($urandom_range(0, sb.atlas_w));
            it.rect_width = (roll < 21) ? srect_pkg::DIM_W'($urandom_range(0, 300))
                                        : srect_pkg::DIM_W'($urandom);
         end
      end else begin
         if (roll < 70 && placed_q.size() > 0) begin
            base = p.placed_height;
            it.rect_height = srect_pkg::DIM_W'(base - $urandom_range(0, base / 3));
         end else if (roll < 95) begin
            it.rect_height = srect_pkg::DIM_W'($urandom_range(0, 48));
         end else begin
            it.rect_height = srect_pkg::DIM_W'($urandom);
         end
         wmax = sb.atlas_w / 6 + 1;
         it.rect_width = ($urandom_range(0, 9) < 8) ? srect_pkg::DIM_W'($urandom_range(0, wmax))
                                                    : srect_pkg::DIM_W'($urandom);
      end
      return it;
   endfunction

   // called just after a falling edge, returns just after a falling edge
   task automatic send(srect_pkg::req_type it);
      srect_pkg::rsp_type want;
      if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = sb.take_request(it);
      if (it.operation == srect_pkg::OP_ALLOC && want.status == srect_pkg::ST_DONE) begin
         placed_q.insert(placed_q.size(), want);
         if (placed_q.size() > 96)
            void'(placed_q.pop_front());
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_atlas(int w, int h);
      csr_we    <= 1'b1;
      csr_index <= srect_pkg::CSR_ATLAS_WIDTH;
      csr_wdata <= srect_pkg::DIM_W'(w);
      @(negedge clock);
      csr_index <= srect_pkg::CSR_ATLAS_HEIGHT;
      csr_wdata <= srect_pkg::DIM_W'(h);
      @(negedge clock);
      csr_we <= 1'b0;
      sb.write_reg(srect_pkg::CSR_ATLAS_WIDTH, w);
      sb.write_reg(srect_pkg::CSR_ATLAS_HEIGHT, h);
      @(negedge clock);
   endtask

   // one table slot is kept back so the closing part can still open a shelf
   task automatic random_phase(int n);
      srect_pkg::req_type it;
      int      tries;
      for (int k = 0; k < n; k++) begin
         tries = 0;
         it = rand_item();
         void'(sb.place_rect(it, 1'b0));
         while (sb.count >= srect_pkg::MAX_SHELVES - 1 && sb.grew && tries < 20) begin
            it = rand_item();
            void'(sb.place_rect(it, 1'b0));
            tries++;
         end
         if (sb.count >= srect_pkg::MAX_SHELVES - 1 && sb.grew)
            it = mk(srect_pkg::OP_ALLOC, 0, 0, DIM_MASK, DIM_MASK);
         send(it);
      end
   endtask

   initial begin
      sb = new();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset atlas size
      send(mk(srect_pkg::OP_FREE, 0, 0, 10, 0));                 // empty table
      send(mk(srect_pkg::OP_ALLOC, 0, 0, 0, 0));                 // zero size opens the top shelf
      send(mk(srect_pkg::OP_ALLOC, 0, 0, 2049, 10));             // wider than the atlas
      send(mk(srect_pkg::OP_ALLOC, DIM_MASK, DIM_MASK, 100, 20));
      send(mk(srect_pkg::OP_ALLOC, 0, 0, 50, 18));               // fits the shelf just opened
      send(mk(srect_pkg::OP_ALLOC, 0, 0, 2048, 30));             // full width, free at minus two
      send(mk(srect_pkg::OP_ALLOC, DIM_MASK, 0, DIM_MASK, DIM_MASK));
      send(mk(srect_pkg::OP_ALLOC, 0, 0, 10, 2048));             // past the bottom
      send(mk(srect_pkg::OP_FREE, 102, 2, 50, 0));               // split
      send(mk(srect_pkg::OP_ALLOC, 0, 0, 40, 18));
      send(mk(srect_pkg::OP_ALLOC, 0, 0, 7, 18));                // free space ends at minus one
      send(mk(srect_pkg::OP_FREE, DIM_MASK, DIM_MASK, DIM_MASK, DIM_MASK));
      send(mk(srect_pkg::OP_FREE, 0, 2, 2049, 0));               // runs past the shelf
      send(mk(srect_pkg::OP_ALLOC, 0, 0, 1, 21));                // just too tall for the shelf
      send(mk(srect_pkg::OP_ALLOC, 0, 0, 1, 14));                // too short for every shelf
      send(mk(srect_pkg::OP_ALLOC, 0, 0, 1, 16));
      send(mk(srect_pkg::OP_ALLOC, 0, 0, 4096, 5));
      send(mk(srect_pkg::OP_FREE, 0, 24, 2048, 0));              // free of a whole shelf
      send(mk(srect_pkg::OP_ALLOC, 0, 0, 2046, 30));
      send(mk(srect_pkg::OP_ALLOC, 0, 0, 0, 0));
      drain();

      set_atlas(4096, 4096);
      random_phase(150);
      drain();

      gap_pct = 40;
      stall_pct = 10;
      set_atlas(1, 4096);
      random_phase(40);
      drain();

      gap_pct = 0;
      stall_pct = 0;
      set_atlas(300, 6000);
      random_phase(60);
      gap_pct = 15;
      stall_pct = 35;
      random_phase(60);
      drain();

      // last part: no idling on either side
      gap_pct = 0;
      stall_pct = 0;
      set_atlas(DIM_MASK, DIM_MASK);
      random_phase(150);

      // zero-width frees at the top shelf fill the table up to one free slot
      for (int i = 0; i < srect_pkg::MAX_SHELVES && sb.count < srect_pkg::MAX_SHELVES - 1; i++)
         send(mk(srect_pkg::OP_FREE, 0, 0, 0, 0));
      // tall shelf drives the row start into saturation
      send(mk(srect_pkg::OP_ALLOC, 0, 0, 5, DIM_MASK - sb.next_row_top));
      send(mk(srect_pkg::OP_ALLOC, 0, 0, 0, 0));
      send(mk(srect_pkg::OP_FREE, 0, 0, 0, 0));
      send(mk(srect_pkg::OP_ALLOC, 0, 0, DIM_MASK, 0));
      send(mk(srect_pkg::OP_FREE, 0, 0, 0, 0));
      drain();
      repeat (srect_pkg::MAX_SHELVES + 16) @(negedge clock);

      $display("covered %0d allocate and %0d free requests, atlas sizes 1 to %0d pixels",
               sb.allocs, sb.frees, DIM_MASK);
      $display("outcomes: %0d done, %0d no space or no shelf, %0d table full; %0d shelves",
               sb.by_status[srect_pkg::ST_DONE], sb.by_status[srect_pkg::ST_MISS],
               sb.by_status[srect_pkg::ST_FULL], sb.count);
      if (sb.mismatches == 0)
         $display("shelf_rect_allocator test passed");
      else
         $display("shelf_rect_allocator test failed");
      $finish;
   end

endmodule
